@@ sv/assert_macros.svh @@
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication in the same cycle
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ sv/thocs_pkg.sv @@
// types and constants for the twelve-hour clock
`timescale 1ns / 1ps

package thocs_pkg;

    localparam int COUNTER_BITS   = 24;
    localparam int THRESH_BITS    = 24;
    localparam int CMP_BITS       = (COUNTER_BITS > THRESH_BITS) ? COUNTER_BITS : THRESH_BITS;

    localparam int SEC_BITS       = 6;
    localparam int MIN_BITS       = 6;
    localparam int HOUR_BITS      = 4;
    localparam int MODE_BITS      = 2;

    localparam logic [SEC_BITS-1:0]  SEC_LAST  = SEC_BITS'(59);
    localparam logic [MIN_BITS-1:0]  MIN_LAST  = MIN_BITS'(59);
    localparam logic [HOUR_BITS-1:0] HOUR_LAST = HOUR_BITS'(11);

    localparam logic [THRESH_BITS-1:0] LONG_PRESS_RESET = THRESH_BITS'(1000000);

    // apb map: one register per 32-bit word
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_IDX_BITS  = CFG_ADDR_BITS - 2;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = CFG_IDX_BITS'(0);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_HOURS   = 2'd1,
        MODE_MINUTES = 2'd2
    } mode_t;

    // press events for one accepted sample
    typedef struct packed {
        logic release_long;
        logic release_short;
        logic held_long;
    } press_evt_t;

    typedef struct packed {
        logic [HOUR_BITS-1:0] hours;
        logic [MIN_BITS-1:0]  minutes;
        logic [MODE_BITS-1:0] mode;
        logic                 hold_indicator;
    } result_t;

endpackage

@@ sv/thocs_press.sv @@
// button press timer and long/short release detection
`timescale 1ns / 1ps

module thocs_press
    import thocs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   button_level,
    input  logic [THRESH_BITS-1:0] threshold,
    output press_evt_t             evt
);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

    logic                    active_reg;
    logic                    active_next;
    logic [COUNTER_BITS-1:0] count_reg;
    logic [COUNTER_BITS-1:0] count_next;
    logic                    pressed;
    logic                    is_long;

    always_comb
    begin
        pressed     = ~button_level;
        is_long     = CMP_BITS'(count_reg) >= CMP_BITS'(threshold);
        active_next = active_reg;
        count_next  = count_reg;
        if (en)
        begin
            if (pressed)
            begin
                active_next = 1'b1;
                if (!active_reg)
                begin
                    count_next = CNT_ONE;
                end
                else if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + CNT_ONE;
                end
            end
            else
            begin
                active_next = 1'b0;
                count_next  = '0;
            end
        end
        evt.release_long  = en && !pressed && active_reg && is_long;
        evt.release_short = en && !pressed && active_reg && !is_long;
        evt.held_long     = active_next
                            && (CMP_BITS'(count_next) >= CMP_BITS'(threshold));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/thocs_skid.sv @@
// output register with one skid entry
`timescale 1ns / 1ps

module thocs_skid
    import thocs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;

    always_comb
    begin
        take            = out_valid_reg && !result_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

@@ sv/twelve_hour_clock_one_button_set.sv @@
// top level: twelve-hour clock set from one push button
// sample channel: one transfer per sample period, carrying second_tick and
//   button_level (low = pressed); accepted when sample_valid is high and
//   sample_stall is low
// result channel: one transfer per sample with hours, minutes, mode and
//   hold_indicator as they stand after that sample
// each result is registered, in the output register or else the skid entry
// throughput: one sample per cycle while sample_stall is low; the clock, press
//   timer and mode update are combinational ahead of the result register
// a stalled result waits in the output register while one more sample is
//   taken into the skid entry; sample_stall rises only once that entry is full
// apb port: long_press_samples at byte address 0, 24 bits, read back in the
//   low bits of prdata; pready is tied high
// reset: time 0:00:00, normal mode, no press in progress, threshold 1000000,
//   result channel empty
`timescale 1ns / 1ps

`include "assert_macros.svh"

module twelve_hour_clock_one_button_set
    import thocs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic                     second_tick,
    input  logic                     button_level,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [HOUR_BITS-1:0]     hours,
    output logic [MIN_BITS-1:0]      minutes,
    output logic [MODE_BITS-1:0]     mode,
    output logic                     hold_indicator
);

    logic [THRESH_BITS-1:0] long_press_reg;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic                   cfg_write;

    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic [SEC_BITS-1:0]    seconds_reg;
    logic [SEC_BITS-1:0]    seconds_next;
    logic [MIN_BITS-1:0]    minutes_reg;
    logic [MIN_BITS-1:0]    minutes_next;
    logic [HOUR_BITS-1:0]   hours_reg;
    logic [HOUR_BITS-1:0]   hours_next;

    logic       sample_accept;
    logic       skid_full;
    press_evt_t evt;
    result_t    new_result;
    result_t    result_data;
    logic       sec_tick;
    logic       sec_wrap;
    logic       min_step;
    logic       min_wrap;
    logic       hour_step;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[CFG_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == REG_LONG_PRESS)
        begin
            prdata = CFG_DATA_BITS'(long_press_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_write && (cfg_idx == REG_LONG_PRESS))
        begin
            long_press_reg <= pwdata[THRESH_BITS-1:0];
        end
    end

    assign sample_stall  = skid_full;
    assign sample_accept = sample_valid && !sample_stall;

    thocs_press u_press (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (sample_accept),
        .button_level (button_level),
        .threshold    (long_press_reg),
        .evt          (evt)
    );

    // mode sequence on long release
    always_comb
    begin
        mode_next = mode_reg;
        if (evt.release_long)
        begin
            unique case (mode_reg)
                MODE_NORMAL:  mode_next = MODE_HOURS;
                MODE_HOURS:   mode_next = MODE_MINUTES;
                MODE_MINUTES: mode_next = MODE_NORMAL;
                default:      mode_next = MODE_NORMAL;
            endcase
        end
    end

    // time counters: tick only runs in normal mode, short press edits
    always_comb
    begin
        sec_tick  = sample_accept && second_tick
                    && (mode_reg != MODE_HOURS) && (mode_reg != MODE_MINUTES);
        sec_wrap  = sec_tick && (seconds_reg == SEC_LAST);
        min_step  = sec_wrap || (evt.release_short && (mode_reg == MODE_MINUTES));
        min_wrap  = min_step && (minutes_reg == MIN_LAST);
        hour_step = min_wrap || (evt.release_short && (mode_reg == MODE_HOURS));

        seconds_next = seconds_reg;
        if (sec_wrap)
        begin
            seconds_next = '0;
        end
        else if (sec_tick)
        begin
            seconds_next = seconds_reg + SEC_BITS'(1);
        end

        minutes_next = minutes_reg;
        if (min_wrap)
        begin
            minutes_next = '0;
        end
        else if (min_step)
        begin
            minutes_next = minutes_reg + MIN_BITS'(1);
        end

        hours_next = hours_reg;
        if (hour_step)
        begin
            hours_next = (hours_reg == HOUR_LAST) ? '0 : hours_reg + HOUR_BITS'(1);
        end

        new_result.hours          = hours_next;
        new_result.minutes        = minutes_next;
        new_result.mode           = mode_next;
        new_result.hold_indicator = evt.held_long;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            seconds_reg <= '0;
            minutes_reg <= '0;
            hours_reg   <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            seconds_reg <= seconds_next;
            minutes_reg <= minutes_next;
            hours_reg   <= hours_next;
        end
    end

    thocs_skid u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (sample_accept),
        .push_data    (new_result),
        .full         (skid_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    assign hours          = result_data.hours;
    assign minutes        = result_data.minutes;
    assign mode           = result_data.mode;
    assign hold_indicator = result_data.hold_indicator;

    `ASSERT_NEXT(a_edit_freezes_seconds,
                 sample_accept && (mode_reg != MODE_NORMAL), $stable(seconds_reg),
                 "seconds moved in an edit mode")
    `ASSERT_NEXT(a_mode_only_on_transfer, !sample_accept, $stable(mode_reg),
                 "mode changed without a sample transfer")
    `ASSERT_IMPLY(a_stall_needs_result, sample_stall, result_valid && hours_reg <= HOUR_LAST,
                  "sample stalled with no result waiting")
    `ASSERT_CLK(a_time_in_range, (hours_reg <= HOUR_LAST) && (minutes_reg <= MIN_LAST)
                && (seconds_reg <= SEC_LAST), "time counter out of range")

endmodule

@@ test/tb.sv @@
// testbench for the twelve-hour clock: random samples checked against a tracked clock face
`timescale 1ns / 1ps

module tb
    import thocs_pkg::*;
;

    // tracks the clock face after every accepted sample and checks returned faces
    class clock_face_tracker;
        logic [SEC_BITS-1:0]     sec_q;
        logic [MIN_BITS-1:0]     min_q;
        logic [HOUR_BITS-1:0]    hour_q;
        mode_t                   mode_q;
        logic [COUNTER_BITS-1:0] press_cnt;
        logic                    press_on;
        logic [THRESH_BITS-1:0]  long_thr;
        result_t                 expected_faces[$];
        int                      mismatches;

        function new();
            sec_q      = '0;
            min_q      = '0;
            hour_q     = '0;
            mode_q     = MODE_NORMAL;
            press_cnt  = '0;
            press_on   = 1'b0;
            long_thr   = LONG_PRESS_RESET;
            mismatches = 0;
        endfunction

        function void set_threshold(logic [THRESH_BITS-1:0] thr);
            long_thr = thr;
        endfunction

        function int pending();
            return expected_faces.size();
        endfunction

        function void bump_hour();
            if (hour_q == HOUR_LAST)
                hour_q = '0;
            else
                hour_q = hour_q + 1'b1;
        endfunction

        function void bump_minute();
            if (min_q == MIN_LAST)
            begin
                min_q = '0;
                bump_hour();
            end
            else
                min_q = min_q + 1'b1;
        endfunction

        function void note_sample(logic tick, logic btn);
            result_t face;
            logic    is_long;
            // tick goes first; edit modes freeze the seconds
            if (tick && mode_q != MODE_HOURS && mode_q != MODE_MINUTES)
            begin
                if (sec_q == SEC_LAST)
                begin
                    sec_q = '0;
                    bump_minute();
                end
                else
                    sec_q = sec_q + 1'b1;
            end
            if (!btn)
            begin
                if (!press_on)
                begin
                    press_on  = 1'b1;
                    press_cnt = COUNTER_BITS'(1);
                end
                else if (press_cnt != {COUNTER_BITS{1'b1}})
                    press_cnt = press_cnt + 1'b1;
            end
            else if (press_on)
            begin
                is_long = CMP_BITS'(press_cnt) >= CMP_BITS'(long_thr);
                if (is_long)
                begin
                    case (mode_q)
                        MODE_NORMAL: mode_q = MODE_HOURS;
                        MODE_HOURS:  mode_q = MODE_MINUTES;
                        default:     mode_q = MODE_NORMAL;
                    endcase
                end
                else if (mode_q == MODE_HOURS)
                    bump_hour();
                else if (mode_q == MODE_MINUTES)
                    bump_minute();
                press_on  = 1'b0;
                press_cnt = '0;
            end
            face.hours          = hour_q;
            face.minutes        = min_q;
            face.mode           = mode_q;
            face.hold_indicator = press_on && (CMP_BITS'(press_cnt) >= CMP_BITS'(long_thr));
            expected_faces.push_back(face);
        endfunction

        function void check_face(result_t got);
            result_t want;
            if (expected_faces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: h=%0d m=%0d mode=%0d hold=%0b",
                             got.hours, got.minutes, got.mode, got.hold_indicator);
                return;
            end
            want = expected_faces.pop_front();
            if (got.hours !== want.hours || got.minutes !== want.minutes ||
                got.mode !== want.mode || got.hold_indicator !== want.hold_indicator)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected h=%0d m=%0d mode=%0d hold=%0b",
                             want.hours, want.minutes, want.mode, want.hold_indicator);
                    $display("          got      h=%0d m=%0d mode=%0d hold=%0b",
                             got.hours, got.minutes, got.mode, got.hold_indicator);
                end
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     sample_valid = 1'b0;
    logic                     sample_stall;
    logic                     second_tick = 1'b0;
    logic                     button_level = 1'b1;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [HOUR_BITS-1:0]     hours;
    logic [MIN_BITS-1:0]      minutes;
    logic [MODE_BITS-1:0]     mode;
    logic                     hold_indicator;

    clock_face_tracker face_track = new();
    int  items_sent = 0;
    int  results_seen = 0;
    int  burst_left = 0;
    int  cfg_errors = 0;
    bit  gaps_on = 1'b1;
    bit  holding_off = 1'b0;

    twelve_hour_clock_one_button_set i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .second_tick    (second_tick),
        .button_level   (button_level),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .hours          (hours),
        .minutes        (minutes),
        .mode           (mode),
        .hold_indicator (hold_indicator)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // result side
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.hours          = hours;
            got.minutes        = minutes;
            got.mode           = mode;
            got.hold_indicator = hold_indicator;
            face_track.check_face(got);
            results_seen++;
        end
    end

    // receiver stall pattern, with one long hold-off to back the block up
    initial
    begin
        int seg_left;
        int pattern;
        int cyc;
        bit hold_done;
        seg_left  = 0;
        pattern   = 0;
        cyc       = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (!hold_done && results_seen >= 700)
            begin
                hold_done    = 1'b1;
                holding_off  = 1'b1;
                result_stall <= 1'b1;
                repeat (400) @(negedge clk);
                holding_off  = 1'b0;
            end
            if (seg_left == 0)
            begin
                pattern  = $urandom_range(0, 3);
                seg_left = $urandom_range(50, 300);
            end
            seg_left--;
            case (pattern)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ((cyc % 5) < 2);
                default: result_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic apb_access(input logic wr, input logic [CFG_DATA_BITS-1:0] data,
                              output logic [CFG_DATA_BITS-1:0] rd);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_LONG_PRESS, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_threshold(input logic [THRESH_BITS-1:0] thr);
        logic [CFG_DATA_BITS-1:0] word;
        logic [CFG_DATA_BITS-1:0] rd;
        // junk in the unused top bits must be dropped
        word = {8'($urandom), thr};
        apb_access(1'b1, word, rd);
        face_track.set_threshold(thr);
        apb_access(1'b0, '0, rd);
        if (rd[THRESH_BITS-1:0] !== thr)
        begin
            cfg_errors++;
            $display("threshold readback: wrote %0d, read %0d", thr, rd[THRESH_BITS-1:0]);
        end
    endtask

    task automatic send_sample(input logic tick, input logic btn);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 30);
            if (gaps_on && !holding_off)
            begin
                gap = $urandom_range(1, 8);
                repeat (gap)
                begin
                    @(negedge clk);
                    sample_valid <= 1'b0;
                end
            end
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        second_tick  <= tick;
        button_level <= btn;
        do @(posedge clk); while (sample_stall);
        face_track.note_sample(tick, btn);
        items_sent++;
        burst_left--;
    endtask

    // len pressed samples with random ticks, then the release
    task automatic press_button(input int len, input logic release_tick);
        repeat (len) send_sample(1'($urandom_range(0, 1)), 1'b0);
        send_sample(release_tick, 1'b1);
    endtask

    // stop offering samples, then wait for every result to come back
    task automatic drain(input int limit);
        int waited;
        waited = 0;
        @(negedge clk);
        sample_valid <= 1'b0;
        while (face_track.pending() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic run_phase(input logic [THRESH_BITS-1:0] thr, input int n_items);
        int  target;
        int  sel;
        int  k;
        int  short_max;
        bit  can_long;
        bit  editing;
        target    = items_sent + n_items;
        can_long  = (thr <= 40);
        short_max = (thr == 0) ? 0 : ((thr - 1 > 30) ? 30 : int'(thr) - 1);
        while (items_sent < target)
        begin
            sel     = $urandom_range(0, 99);
            editing = (face_track.mode_q != MODE_NORMAL);
            if (editing && sel < 45 && short_max > 0)
            begin
                // runs of short presses push the edited field through its wrap
                k = $urandom_range(3, 25);
                for (int j = 0; j < k && items_sent < target; j++)
                    press_button($urandom_range(1, short_max), 1'($urandom_range(0, 1)));
            end
            else if (sel < 60)
            begin
                k = $urandom_range(1, 20);
                repeat (k) send_sample(($urandom_range(0, 3) != 0), 1'b1);
            end
            else if (sel < 80 && can_long)
                press_button(((thr == 0) ? 1 : int'(thr)) + $urandom_range(0, 3),
                             1'($urandom_range(0, 1)));
            else if (sel < 90 && short_max > 0)
                press_button($urandom_range(1, short_max), 1'($urandom_range(0, 1)));
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k) send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        logic [THRESH_BITS-1:0] thr_list [8];
        thr_list[0] = THRESH_BITS'(3);
        thr_list[1] = THRESH_BITS'(1);
        thr_list[2] = '0;
        thr_list[3] = {THRESH_BITS{1'b1}};
        thr_list[4] = THRESH_BITS'(6);
        thr_list[5] = THRESH_BITS'(2);
        thr_list[6] = THRESH_BITS'($urandom_range(2, 8));
        thr_list[7] = THRESH_BITS'(4);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset threshold: every press is short, so normal mode ignores them
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        drain(5000);

        write_threshold(THRESH_BITS'(2));
        // long press released together with a tick: the tick still counts
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b1);
        // tick ignored while editing hours, short press adds an hour
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b1);
        press_button(2, 1'b0);
        press_button(1, 1'b1);
        press_button(1, 1'b0);
        press_button(3, 1'b1);
        send_sample(1'b1, 1'b1);
        drain(5000);

        for (int p = 0; p < 8; p++)
        begin
            gaps_on = (p % 2 == 0);
            write_threshold(thr_list[p]);
            run_phase(thr_list[p], 180);
            drain(5000);
        end

        @(negedge clk);
        sample_valid <= 1'b0;
        drain(5000);
        repeat (8) @(posedge clk);
        if (face_track.mismatches == 0 && face_track.pending() == 0 && cfg_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/thocs_pkg.sv
sv/thocs_press.sv
sv/thocs_skid.sv
sv/twelve_hour_clock_one_button_set.sv
test/tb.sv
